// ===== design/pbeq_pkg.sv =====
// ----------------------------------------------------------------------------
// pbeq_pkg
// Shared types and constants for the pointer button event qualifier.
// ----------------------------------------------------------------------------
package pbeq_pkg;

  localparam int NBTN = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W = 72;
  localparam int OUT_TDATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK_MS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_HANDED     = 2'd3;

  localparam logic [12:0] RST_SCREEN_WIDTH    = 13'd640;
  localparam logic [12:0] RST_SCREEN_HEIGHT   = 13'd480;
  localparam logic [15:0] RST_DOUBLE_CLICK_MS = 16'd500;

  typedef struct packed {
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [15:0] double_click_ms;
    logic        left_handed;
  } cfg_t;

  typedef struct packed {
    logic                window_active;
    logic [NBTN-1:0]     released_levels;
    logic [NBTN-1:0]     press_edges;
    logic [31:0]         now_ms;
    logic signed [15:0]  raw_y;
    logic signed [15:0]  raw_x;
  } in_item_t;

  typedef struct packed {
    logic [NBTN-1:0]     held_flags;
    logic [NBTN-1:0]     double_pulses;
    logic [NBTN-1:0]     up_pulses;
    logic [NBTN-1:0]     down_pulses;
    logic signed [12:0]  delta_y;
    logic signed [12:0]  delta_x;
    logic [11:0]         cursor_y;
    logic [11:0]         cursor_x;
  } out_item_t;

endpackage

// ===== design/pointer_button_event_qualifier.sv =====
// ----------------------------------------------------------------------------
// pointer_button_event_qualifier
// Clamps the cursor, reports deltas and qualifies button down, up and double
// click events once per frame tick.
// ----------------------------------------------------------------------------
// a result word reaches m_tvalid from its accepted input word through the
//   input register, then the result register
// throughput: one word per cycle unless m_tready stalls; the tracking state
//   updates as a word moves from the input into the result register
// reset: rst (synchronous) empties both registers, clears cursor, arming,
//   press times and held flags, and loads the register defaults
module pointer_button_event_qualifier (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // raw_x[15:0], raw_y[31:16], now_ms[63:32], press_edges[66:64],
  // released_levels[69:67], window_active[70], zero[71]
  input  logic [pbeq_pkg::IN_TDATA_W-1:0]  s_tdata,
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // cursor_x[11:0], cursor_y[23:12], delta_x[36:24], delta_y[49:37],
  // down_pulses[52:50], up_pulses[55:53], double_pulses[58:56],
  // held_flags[61:59], zero[63:62]
  output logic [pbeq_pkg::OUT_TDATA_W-1:0] m_tdata,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pbeq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pbeq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pbeq_pkg::*;

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  out_item_t result;
  out_item_t m_item;
  logic      advance;

  pbeq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // a word leaves the input register when the result register is free or
  // being drained in the same cycle
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item <= s_tdata[$bits(in_item_t)-1:0];
    end
  end

  // event logic and tracking state, stepped as the word advances
  pbeq_qual u_qual (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .cfg    (cfg),
    .item   (s1_item),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_item <= result;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - $bits(out_item_t)){1'b0}}, m_item};

endmodule

// ===== design/pbeq_cfg.sv =====
// ----------------------------------------------------------------------------
// pbeq_cfg
// Configuration register file, written through the config channel.
// ----------------------------------------------------------------------------
module pbeq_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pbeq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbeq_pkg::CFG_DATA_W-1:0] cfg_data,
  output pbeq_pkg::cfg_t                  cfg
);
  import pbeq_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width    <= RST_SCREEN_WIDTH;
      cfg.screen_height   <= RST_SCREEN_HEIGHT;
      cfg.double_click_ms <= RST_DOUBLE_CLICK_MS;
      cfg.left_handed     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:    cfg.screen_width    <= cfg_data[12:0];
        REG_SCREEN_HEIGHT:   cfg.screen_height   <= cfg_data[12:0];
        REG_DOUBLE_CLICK_MS: cfg.double_click_ms <= cfg_data;
        REG_LEFT_HANDED:     cfg.left_handed     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/pbeq_qual.sv =====
// ----------------------------------------------------------------------------
// pbeq_qual
// Cursor clamp, delta and button event qualification with tracking state.
// ----------------------------------------------------------------------------
module pbeq_qual (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  pbeq_pkg::cfg_t      cfg,
  input  pbeq_pkg::in_item_t  item,
  output pbeq_pkg::out_item_t result
);
  import pbeq_pkg::*;

  logic [11:0]           prev_x;
  logic [11:0]           prev_y;
  logic [31:0]           last_press_time [NBTN];
  logic [NBTN-1:0]       armed;
  logic [NBTN-1:0]       held;

  logic [11:0]           max_x;
  logic [11:0]           max_y;
  logic [11:0]           cx;
  logic [11:0]           cy;
  logic signed [12:0]    dx;
  logic signed [12:0]    dy;
  logic                  moved;
  logic [NBTN-1:0]       armed_next;
  logic [NBTN-1:0]       held_next;
  logic [NBTN-1:0]       dn;
  logic [NBTN-1:0]       up;
  logic [NBTN-1:0]       dbl;
  logic [31:0]           gap [NBTN];

  // largest legal coordinate: limit of 0 acts as 1, above 4096 as 4096
  function automatic logic [11:0] axis_max(input logic [12:0] lim);
    logic [12:0] m;
    begin
      m = lim - 13'd1;
      if (lim == 13'd0) return 12'd0;
      else if (lim[12]) return 12'hfff;
      else return m[11:0];
    end
  endfunction

  function automatic logic [11:0] clamp(input logic signed [15:0] v, input logic [11:0] mx);
    begin
      if (v[15]) return 12'd0;
      else if (v[14:0] > {3'b000, mx}) return mx;
      else return v[11:0];
    end
  endfunction

  always_comb begin
    max_x = axis_max(cfg.screen_width);
    max_y = axis_max(cfg.screen_height);
    cx    = clamp(item.raw_x, max_x);
    cy    = clamp(item.raw_y, max_y);
    dx    = $signed({1'b0, cx}) - $signed({1'b0, prev_x});
    dy    = $signed({1'b0, cy}) - $signed({1'b0, prev_y});
    moved = (cx != prev_x) || (cy != prev_y);

    armed_next = moved ? '0 : armed;
    held_next  = held;
    dn         = '0;
    up         = '0;
    dbl        = '0;
    for (int p = 0; p < NBTN; p++) begin
      int lg;
      lg     = (cfg.left_handed && p < 2) ? 1 - p : p;
      gap[p] = item.now_ms - last_press_time[p];
      if (item.press_edges[p]) begin
        if (armed_next[p] && gap[p] <= {16'd0, cfg.double_click_ms}) begin
          dbl[lg]       = 1'b1;
          armed_next[p] = 1'b0;
        end else begin
          armed_next[p] = 1'b1;
        end
        dn[lg]        = 1'b1;
        held_next[lg] = 1'b1;
      end else if (item.released_levels[p] && held[lg]) begin
        held_next[lg] = 1'b0;
        up[lg]        = 1'b1;
      end
    end

    result.held_flags = held_next;
    if (item.window_active) begin
      result.cursor_x      = cx;
      result.cursor_y      = cy;
      result.delta_x       = dx;
      result.delta_y       = dy;
      result.down_pulses   = dn;
      result.up_pulses     = up;
      result.double_pulses = dbl;
    end else begin
      result.cursor_x      = '0;
      result.cursor_y      = '0;
      result.delta_x       = '0;
      result.delta_y       = '0;
      result.down_pulses   = '0;
      result.up_pulses     = '0;
      result.double_pulses = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
      armed  <= '0;
      held   <= '0;
      for (int p = 0; p < NBTN; p++) last_press_time[p] <= '0;
    end else if (step) begin
      prev_x <= cx;
      prev_y <= cy;
      armed  <= armed_next;
      held   <= held_next;
      for (int p = 0; p < NBTN; p++) begin
        if (item.press_edges[p]) last_press_time[p] <= item.now_ms;
      end
    end
  end

endmodule

// ===== design/pbeq_checker.sv =====
// ----------------------------------------------------------------------------
// pbeq_checker
// Port level checks on the result stream of the event qualifier.
// ----------------------------------------------------------------------------
module pbeq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [pbeq_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import pbeq_pkg::*;

  logic [NBTN-1:0] dn;
  logic [NBTN-1:0] up;
  logic [NBTN-1:0] dbl;
  logic [NBTN-1:0] hf;

  assign dn  = m_tdata[52:50];
  assign up  = m_tdata[55:53];
  assign dbl = m_tdata[58:56];
  assign hf  = m_tdata[61:59];

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // a double click is always also a press
  a_dbl_dn: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (dbl & ~dn) == '0)
    else $error("double pulse without down pulse");

  // a pressed button is held afterwards
  a_dn_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (dn & ~hf) == '0)
    else $error("down pulse on a button not held");

  // a released button is no longer held
  a_up_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (up & hf) == '0)
    else $error("up pulse on a button still held");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[63:62] == 2'b00)
    else $error("nonzero padding in result word");

endmodule

bind pointer_button_event_qualifier pbeq_checker u_pbeq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pointer button event qualifier. A directed
// table covers clamping, button timing and handedness corners, then phases
// of random frame ticks run under several register settings. Every result
// word is checked field by field against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import pbeq_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no word moving anywhere
  localparam int SETTLE_CYCLES = 4;   // pipeline is two registers deep
  localparam int PHASES = 8;
  localparam int PHASE_TICKS = 118;
  localparam int REPORT_MAX = 10;

  // directed table rows: either a frame tick or a full register setting
  typedef enum logic {ROW_TICK, ROW_SETTING} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    in_item_t    stim;
    bit          typed;   // want holds a hand-written expectation
    out_item_t   want;
    logic [15:0] set_w;
    logic [15:0] set_h;
    logic [15:0] set_dc;
    logic [15:0] set_lh;
  } row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // register shadow, follows every accepted config word
  logic [12:0] cfg_w = RST_SCREEN_WIDTH;
  logic [12:0] cfg_h = RST_SCREEN_HEIGHT;
  logic [15:0] cfg_dc = RST_DOUBLE_CLICK_MS;
  logic        cfg_lh = 1'b0;

  // tracking state of the predictor
  logic [11:0] last_x = '0;
  logic [11:0] last_y = '0;
  logic [31:0] press_stamp [NBTN] = '{default: '0};
  logic [NBTN-1:0] dbl_armed = '0;  // per physical button
  logic [NBTN-1:0] btn_held = '0;   // per logical button

  out_item_t pending_reports [$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        gaps_on = 1'b1;  // random idling on both streams

  pointer_button_event_qualifier dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // clamp one axis; a limit of 0 acts as 1, anything above 4096 as 4096
  function automatic logic [11:0] clamp_axis_to(input logic signed [15:0] v,
                                                input logic [12:0] lim_reg);
    int lim;
    lim = int'(lim_reg);
    if (lim < 1) lim = 1;
    if (lim > 4096) lim = 4096;
    if (v < 0) return '0;
    if (int'(v) > lim - 1) return 12'(lim - 1);
    return v[11:0];
  endfunction

  // expected result of one frame tick; advances the tracking state
  task automatic qualify_tick(input in_item_t w, output out_item_t r);
    logic [11:0] cx;
    logic [11:0] cy;
    logic [12:0] dx;
    logic [12:0] dy;
    logic [NBTN-1:0] dn;
    logic [NBTN-1:0] up;
    logic [NBTN-1:0] dbl;
    logic [31:0] gap;
    int lg;
    cx = clamp_axis_to(w.raw_x, cfg_w);
    cy = clamp_axis_to(w.raw_y, cfg_h);
    dx = {1'b0, cx} - {1'b0, last_x};
    dy = {1'b0, cy} - {1'b0, last_y};
    dn = '0;
    up = '0;
    dbl = '0;
    // any movement at all cancels every pending double click
    if (dx != 0 || dy != 0) dbl_armed = '0;
    last_x = cx;
    last_y = cy;
    for (int p = 0; p < NBTN; p++) begin
      lg = (cfg_lh && p < 2) ? 1 - p : p;
      if (w.press_edges[p]) begin
        // press wins over a released level on the same button
        gap = w.now_ms - press_stamp[p];
        if (dbl_armed[p] && gap <= {16'd0, cfg_dc}) begin
          dbl[lg] = 1'b1;
          dbl_armed[p] = 1'b0;
        end else begin
          dbl_armed[p] = 1'b1;
        end
        dn[lg] = 1'b1;
        btn_held[lg] = 1'b1;
        press_stamp[p] = w.now_ms;
      end else if (w.released_levels[p] && btn_held[lg]) begin
        btn_held[lg] = 1'b0;
        up[lg] = 1'b1;
      end
    end
    r = '0;
    r.held_flags = btn_held;  // reported even with the window inactive
    if (w.window_active) begin
      r.cursor_x = cx;
      r.cursor_y = cy;
      r.delta_x = dx;
      r.delta_y = dy;
      r.down_pulses = dn;
      r.up_pulses = up;
      r.double_pulses = dbl;
    end
  endtask

  function automatic row_t tick_row(input int x, input int y, input logic [31:0] ms,
                                    input int pe, input int rl, input bit act);
    row_t r;
    r.kind = ROW_TICK;
    r.stim = '0;
    r.stim.raw_x = 16'(x);
    r.stim.raw_y = 16'(y);
    r.stim.now_ms = ms;
    r.stim.press_edges = NBTN'(pe);
    r.stim.released_levels = NBTN'(rl);
    r.stim.window_active = act;
    r.typed = 1'b0;
    r.want = '0;
    r.set_w = '0;
    r.set_h = '0;
    r.set_dc = '0;
    r.set_lh = '0;
    return r;
  endfunction

  function automatic row_t checked_row(input int x, input int y, input logic [31:0] ms,
                                       input int pe, input int rl, input bit act,
                                       input int cx, input int cy, input int dx,
                                       input int dy, input int dn, input int up,
                                       input int dbl, input int hf);
    row_t r;
    r = tick_row(x, y, ms, pe, rl, act);
    r.typed = 1'b1;
    r.want.cursor_x = 12'(cx);
    r.want.cursor_y = 12'(cy);
    r.want.delta_x = 13'(dx);
    r.want.delta_y = 13'(dy);
    r.want.down_pulses = NBTN'(dn);
    r.want.up_pulses = NBTN'(up);
    r.want.double_pulses = NBTN'(dbl);
    r.want.held_flags = NBTN'(hf);
    return r;
  endfunction

  function automatic row_t setting_row(input logic [15:0] w, input logic [15:0] h,
                                       input logic [15:0] dc, input logic [15:0] lh);
    row_t r;
    r = tick_row(0, 0, 0, 0, 0, 1'b0);
    r.kind = ROW_SETTING;
    r.set_w = w;
    r.set_h = h;
    r.set_dc = dc;
    r.set_lh = lh;
    return r;
  endfunction

  // screen extent for a random setting, small sizes favored
  function automatic logic [15:0] pick_extent();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd4096;
      3: return 16'd8191;
      4: return 16'hFFFF;
      5: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 24));
    endcase
  endfunction

  // offer one tick word; valid is left high so a following word can go
  // back to back, the caller lowers it when the burst ends
  task automatic send_tick(input in_item_t w, input bit typed, input out_item_t typed_want);
    out_item_t predicted;
    while (gaps_on && $urandom_range(0, 99) < 6) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_TDATA_W - $bits(in_item_t)){1'b0}}, w};
    do @(posedge clk); while (!s_tready);
    qualify_tick(w, predicted);
    pending_reports.push_back(typed ? typed_want : predicted);
  endtask

  // let every expected result come back, then let the pipeline empty
  task automatic drain_results();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four registers back to back
  task automatic program_regs(input logic [15:0] w, input logic [15:0] h,
                              input logic [15:0] dc, input logic [15:0] lh);
    logic [15:0] vals [4];
    logic [CFG_IDX_W-1:0] idxs [4];
    vals = '{w, h, dc, lh};
    idxs = '{REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_DOUBLE_CLICK_MS, REG_LEFT_HANDED};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idxs[i])
        REG_SCREEN_WIDTH:    cfg_w = vals[i][12:0];
        REG_SCREEN_HEIGHT:   cfg_h = vals[i][12:0];
        REG_DOUBLE_CLICK_MS: cfg_dc = vals[i];
        REG_LEFT_HANDED:     cfg_lh = vals[i][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_field(input string name, input logic signed [31:0] want,
                            input logic signed [31:0] got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch %s: expected %0d got %0d", name, want, got);
  endtask

  // result stream: random back pressure, long calm stretch when gaps_on is off
  always @(posedge clk) begin
    m_tready <= !(gaps_on && $urandom_range(0, 99) < 6);
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t got;
    out_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(out_item_t)-1:0];
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result word %h", m_tdata);
      end else begin
        want = pending_reports.pop_front();
        if (got.cursor_x !== want.cursor_x)
          flag_field("cursor_x", 32'(want.cursor_x), 32'(got.cursor_x));
        if (got.cursor_y !== want.cursor_y)
          flag_field("cursor_y", 32'(want.cursor_y), 32'(got.cursor_y));
        if (got.delta_x !== want.delta_x)
          flag_field("delta_x", 32'(want.delta_x), 32'(got.delta_x));
        if (got.delta_y !== want.delta_y)
          flag_field("delta_y", 32'(want.delta_y), 32'(got.delta_y));
        if (got.down_pulses !== want.down_pulses)
          flag_field("down_pulses", 32'(want.down_pulses), 32'(got.down_pulses));
        if (got.up_pulses !== want.up_pulses)
          flag_field("up_pulses", 32'(want.up_pulses), 32'(got.up_pulses));
        if (got.double_pulses !== want.double_pulses)
          flag_field("double_pulses", 32'(want.double_pulses), 32'(got.double_pulses));
        if (got.held_flags !== want.held_flags)
          flag_field("held_flags", 32'(want.held_flags), 32'(got.held_flags));
      end
    end
  end

  // watchdog: too long with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    row_t plan [$];
    in_item_t w;
    logic [95:0] noise;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0] stamp_ms;

    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed table, starting from the reset setting 640x480, 500 ms
    // still at origin right after reset
    plan.push_back(checked_row(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    // far off screen in both directions
    plan.push_back(checked_row(32767, 32767, 10, 0, 0, 1, 639, 479, 639, 479, 0, 0, 0, 0));
    plan.push_back(checked_row(-32768, -32768, 20, 0, 0, 1, 0, 0, -639, -479, 0, 0, 0, 0));
    // first press arms, second one exactly at the limit is a double click
    plan.push_back(checked_row(0, 0, 1000, 1, 0, 1, 0, 0, 0, 0, 1, 0, 0, 1));
    plan.push_back(checked_row(0, 0, 1500, 1, 0, 1, 0, 0, 0, 0, 1, 0, 1, 1));
    plan.push_back(tick_row(0, 0, 2000, 1, 0, 1));   // re-arms after the double
    plan.push_back(tick_row(0, 0, 2501, 1, 0, 1));   // one ms too late
    plan.push_back(tick_row(0, 0, 2600, 0, 7, 1));   // release of held left
    plan.push_back(tick_row(0, 0, 2700, 0, 7, 1));   // release of nothing held
    plan.push_back(tick_row(0, 0, 2800, 2, 2, 1));   // press and release together
    plan.push_back(tick_row(5, 0, 2900, 2, 0, 1));   // movement kills the arming
    plan.push_back(tick_row(5, 0, 3000, 4, 0, 0));   // inactive window still arms
    plan.push_back(tick_row(5, 0, 3100, 4, 0, 1));   // double after inactive tick
    plan.push_back(tick_row(5, 0, 32'hFFFF_FF00, 4, 0, 1));
    plan.push_back(tick_row(5, 0, 32'h0000_0010, 4, 3, 1));  // gap wraps past 2^32
    // zero width acts as one, oversize height as 4096, swapped buttons
    plan.push_back(setting_row(16'd0, 16'd8191, 16'd0, 16'd1));
    plan.push_back(tick_row(100, 5000, 50, 0, 0, 1));
    plan.push_back(tick_row(100, 5000, 60, 1, 0, 1));  // physical 0 is right now
    plan.push_back(tick_row(100, 5000, 60, 1, 0, 1));  // zero gap, zero limit
    plan.push_back(tick_row(100, 5000, 70, 0, 3, 1));
    plan.push_back(tick_row(-1, -1, 80, 7, 0, 1));
    // handedness flips while buttons are held
    plan.push_back(setting_row(16'd4096, 16'd1, 16'd65535, 16'd0));
    plan.push_back(tick_row(32767, -5, 90, 0, 1, 1));
    plan.push_back(tick_row(4096, 32767, 100, 0, 6, 1));
    plan.push_back(tick_row(4095, 0, 100, 2, 0, 1));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SETTING) begin
        s_tvalid <= 1'b0;
        drain_results();
        program_regs(plan[i].set_w, plan[i].set_h, plan[i].set_dc, plan[i].set_lh);
      end else begin
        send_tick(plan[i].stim, plan[i].typed, plan[i].want);
      end
    end
    s_tvalid <= 1'b0;

    // --- random phases, each under its own register setting
    pos_x = '0;
    pos_y = '0;
    stamp_ms = $urandom;
    for (int ph = 0; ph < PHASES; ph++) begin
      // sender holds off here until every result of the last phase is back
      drain_results();
      case (ph)
        0: program_regs(16'(RST_SCREEN_WIDTH), 16'(RST_SCREEN_HEIGHT),
                        RST_DOUBLE_CLICK_MS, 16'd0);
        1: program_regs(16'd1, 16'd1, 16'd65535, 16'd1);
        2: program_regs(16'd4096, 16'd4096, 16'd0, 16'd0);
        3: program_regs(16'($urandom_range(1, 16)), 16'($urandom_range(1, 16)),
                        16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1)));
        default: program_regs(pick_extent(), pick_extent(),
                              ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 900)),
                              16'($urandom));
      endcase
      gaps_on = (ph != 3);  // one phase with no idling at all
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if ($urandom_range(0, 7) == 0) begin
          // noise: every field fully random
          noise = {$urandom, $urandom, $urandom};
          w = noise[$bits(in_item_t)-1:0];
        end else begin
          // mostly a still cursor so presses can pair up into double clicks
          if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 7) == 0) begin
              pos_x = 16'($urandom);
              pos_y = 16'($urandom);
            end else begin
              pos_x = 16'($urandom_range(0, 40) - 8);
              pos_y = 16'($urandom_range(0, 40) - 8);
            end
          end
          stamp_ms += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 800);
          w = '0;
          w.raw_x = pos_x;
          w.raw_y = pos_y;
          w.now_ms = stamp_ms;
          w.press_edges = NBTN'(($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0);
          w.released_levels = NBTN'($urandom_range(0, 7));
          w.window_active = ($urandom_range(0, 9) != 0);
        end
        send_tick(w, 1'b0, '0);
      end
      s_tvalid <= 1'b0;
    end

    gaps_on = 1'b1;
    drain_results();
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pbeq_pkg.sv
design/pbeq_cfg.sv
design/pbeq_qual.sv
design/pointer_button_event_qualifier.sv
design/pbeq_checker.sv
tb/tb_top.sv
